// ----- rtl/lwcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lwcs_pkg
// Shared types and constants for one set of the LRU write-back cache: the
// access and result payloads carried on the valid/ready channels.
// ----------------------------------------------------------------------------
package lwcs_pkg;

  // Fixed field widths of the access payload
  localparam int unsigned LINE_TAG_W = 48;
  // Widest tag the set can store
  localparam int unsigned MAX_TAG_W  = 64;

  // One access presented to the set
  typedef struct packed {
    logic [LINE_TAG_W-1:0] line_tag;
    logic                  is_write;
  } access_t;

  // One result returned per access
  typedef struct packed {
    logic hit;
    logic dirty_writeback;
  } result_t;

endpackage

// ----- rtl/lru_writeback_cache_set.sv -----
// ----------------------------------------------------------------------------
// lru_writeback_cache_set
// One set of a WAYS-way write-back cache with true LRU replacement and
// per-way dirty flags.
// ----------------------------------------------------------------------------
// Usage:
//   access channel (access_valid/access_ready/access) carries a line tag and
//   a write flag. result channel (result_valid/result_ready/result) returns
//   exactly one result per access, in order: hit, and whether a miss evicted
//   a dirty line.
//   An accepted access lands in an input register. When it moves on, the tag
//   compare, victim choice, LRU rank update and dirty update all happen in
//   one pass and the result is loaded into the output register, which
//   drives result_valid and the result. One access per cycle is sustained
//   while the receiver does not stall; the single-pass tag compare and rank
//   update set that figure.
//   Reset empties the set at once: fill count and dirty flags clear, no
//   clearing pass is needed. Tags are written on fill and are never read
//   before that.
//   When the receiver stalls, the result register holds its value, one more
//   access may wait in the input register, and access_ready then drops until
//   the result is taken.
// ----------------------------------------------------------------------------
module lru_writeback_cache_set #(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned TAG_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              access_valid,
  output logic              access_ready,
  input  lwcs_pkg::access_t access,
  output logic              result_valid,
  input  logic              result_ready,
  output lwcs_pkg::result_t result
);

  import lwcs_pkg::*;

  localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(WAYS + 1);

  // Input register
  logic    stage_valid;
  access_t stage;

  // Set state
  logic [TAG_BITS-1:0] tag_store [WAYS];
  logic [RANK_W-1:0]   age_rank  [WAYS];
  logic [WAYS-1:0]     dirty_flags;
  logic [CNT_W-1:0]    fill_count;

  // Single-pass update signals
  logic                advance;
  logic [MAX_TAG_W-1:0] tag_ext;
  logic [TAG_BITS-1:0] tag;
  logic [WAYS-1:0]     filled;
  logic [WAYS-1:0]     match;
  logic [WAYS-1:0]     hit_oh;
  logic [WAYS-1:0]     oldest;
  logic [WAYS-1:0]     victim_oh;
  logic [WAYS-1:0]     fill_oh;
  logic [WAYS-1:0]     way_oh;
  logic                hit;
  logic                full;
  logic [RANK_W-1:0]   hit_rank;
  logic [CNT_W-1:0]    old_rank;
  logic [CNT_W-1:0]    fill_count_next;
  logic [RANK_W-1:0]   age_rank_next [WAYS];
  logic [WAYS-1:0]     dirty_flags_next;
  logic                dirty_old;
  result_t             result_next;

  // Move the staged access on when the result register is free or emptying
  assign advance      = stage_valid && (!result_valid || result_ready);
  assign access_ready = !stage_valid || advance;

  // Keep the low TAG_BITS bits of the zero-extended tag
  assign tag_ext = MAX_TAG_W'(stage.line_tag);
  assign tag     = tag_ext[TAG_BITS-1:0];

  // Compare filled ways, pick the accessed way and work out the new state
  always_comb begin
    full     = (fill_count == CNT_W'(WAYS));
    hit_rank = '0;
    for (int i = 0; i < WAYS; i++) begin
      filled[i]  = (CNT_W'(i) < fill_count);
      match[i]   = filled[i] && (tag_store[i] == tag);
      oldest[i]  = (age_rank[i] == RANK_W'(WAYS - 1));
      fill_oh[i] = (CNT_W'(i) == fill_count);
    end
    hit       = |match;
    hit_oh    = match & (~match + WAYS'(1));
    victim_oh = oldest & (~oldest + WAYS'(1));
    for (int i = 0; i < WAYS; i++) begin
      if (hit_oh[i]) begin
        hit_rank = hit_rank | age_rank[i];
      end
    end

    if (hit) begin
      way_oh          = hit_oh;
      old_rank        = CNT_W'(hit_rank);
      fill_count_next = fill_count;
    end else if (full) begin
      way_oh          = victim_oh;
      old_rank        = CNT_W'(WAYS - 1);
      fill_count_next = fill_count;
    end else begin
      way_oh          = fill_oh;
      old_rank        = fill_count + CNT_W'(1);
      fill_count_next = fill_count + CNT_W'(1);
    end

    // Age every filled way younger than the accessed one; make it youngest
    for (int i = 0; i < WAYS; i++) begin
      if (way_oh[i]) begin
        age_rank_next[i] = '0;
      end else if ((CNT_W'(i) < fill_count_next) && (CNT_W'(age_rank[i]) < old_rank)) begin
        age_rank_next[i] = age_rank[i] + RANK_W'(1);
      end else begin
        age_rank_next[i] = age_rank[i];
      end
    end

    // Dirty on a write, or on a hit to a dirty line
    dirty_old = |(way_oh & dirty_flags);
    for (int i = 0; i < WAYS; i++) begin
      if (way_oh[i]) begin
        dirty_flags_next[i] = stage.is_write || (hit && dirty_flags[i]);
      end else begin
        dirty_flags_next[i] = dirty_flags[i];
      end
    end

    result_next.hit             = hit;
    result_next.dirty_writeback = !hit && dirty_old;
  end

  // Input register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (access_ready) begin
      stage_valid <= access_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (access_ready && access_valid) begin
      stage <= access;
    end
  end

  // Set state update, one access per cycle while the staged access advances
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      dirty_flags <= '0;
      for (int i = 0; i < WAYS; i++) begin
        age_rank[i] <= '0;
      end
    end else if (advance) begin
      fill_count  <= fill_count_next;
      dirty_flags <= dirty_flags_next;
      for (int i = 0; i < WAYS; i++) begin
        age_rank[i] <= age_rank_next[i];
      end
    end
  end

  // Write the tag into the filled or replaced way on a miss
  always_ff @(posedge clk) begin
    for (int i = 0; i < WAYS; i++) begin
      if (advance && !hit && way_oh[i]) begin
        tag_store[i] <= tag;
      end
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/lwcs_checker.sv -----
// ----------------------------------------------------------------------------
// lwcs_checker
// Port-level checks for one LRU write-back cache set, bound into every instance.
// ----------------------------------------------------------------------------
module lwcs_checker (
  input logic              clk,
  input logic              rst,
  input logic              access_ready,
  input logic              result_valid,
  input logic              result_ready,
  input lwcs_pkg::result_t result
);

  import lwcs_pkg::*;

  // Leave reset with nothing to deliver
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid just after reset");

  // Hold a stalled result
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("stalled result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("stalled result changed");

  // Refuse accesses only while a result is waiting on a stalled receiver
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !access_ready |-> result_valid && !result_ready)
    else $error("access refused without output stall");

  // A hit never evicts
  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.hit && result.dirty_writeback))
    else $error("write-back reported on a hit");

endmodule

bind lru_writeback_cache_set lwcs_checker u_lwcs_checker (
  .clk          (clk),
  .rst          (rst),
  .access_ready (access_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- sim/lwcs_checker.sv -----
// ----------------------------------------------------------------------------
// lwcs_scoreboard
// Watches both channels of the cache set, keeps its own copy of the tags,
// LRU ranks and dirty flags, and compares every result transfer with the
// oldest prediction. Reports mismatches and hands the failure count and the
// number of results still in flight to the testbench top.
// ----------------------------------------------------------------------------
module lwcs_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              access_valid,
  input  logic              access_ready,
  input  lwcs_pkg::access_t access,
  input  logic              result_valid,
  input  logic              result_ready,
  input  lwcs_pkg::result_t result,
  output int                fail_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WAYS     = 8;
  localparam int unsigned TAG_BITS = 48;

  typedef logic [TAG_BITS-1:0] tag_t;

  // Shadow of the set
  tag_t       way_tag    [WAYS];
  logic [2:0] lru_rank   [WAYS];
  logic       way_dirty  [WAYS];
  logic [3:0] ways_filled;

  // Predicted results, oldest first
  lwcs_pkg::result_t expected_lookups [$];

  // Look the tag up, pick the way, age the others and update the dirty flag
  function automatic lwcs_pkg::result_t predict_lookup(lwcs_pkg::access_t a);
    lwcs_pkg::result_t outcome;
    tag_t              tag;
    logic              found;
    int unsigned       way;
    int unsigned       old_rank;
    int unsigned       i;
    tag      = a.line_tag[TAG_BITS-1:0];
    found    = 1'b0;
    way      = 0;
    old_rank = 0;
    // compare filled ways only, lowest index first
    for (i = 0; i < ways_filled; i++) begin
      if (!found && way_tag[i] == tag) begin
        found = 1'b1;
        way   = i;
      end
    end
    if (found) begin
      old_rank = lru_rank[way];
    end else if (ways_filled < WAYS) begin
      // fill the next empty way; it counts as older than every filled way
      way          = ways_filled;
      ways_filled  = ways_filled + 1'b1;
      old_rank     = ways_filled;
      way_tag[way] = tag;
    end else begin
      // replace the oldest way, lowest index on a tie
      way = 0;
      for (i = 1; i < WAYS; i++) begin
        if (lru_rank[i] > lru_rank[way]) way = i;
      end
      old_rank     = lru_rank[way];
      way_tag[way] = tag;
    end
    // age the ways that were younger than the touched one
    for (i = 0; i < ways_filled; i++) begin
      if (i != way && lru_rank[i] < old_rank) lru_rank[i] = lru_rank[i] + 1'b1;
    end
    lru_rank[way]           = '0;
    outcome.hit             = found;
    outcome.dirty_writeback = !found && way_dirty[way];
    way_dirty[way]          = a.is_write || (found && way_dirty[way]);
    return outcome;
  endfunction

  // Track transfers on both channels
  always @(posedge clk) begin : watch
    lwcs_pkg::result_t want;
    int unsigned       w;
    if (rst) begin
      for (w = 0; w < WAYS; w++) begin
        way_tag[w]   = '0;
        lru_rank[w]  = '0;
        way_dirty[w] = 1'b0;
      end
      ways_filled = '0;
      expected_lookups.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      // check the result transfer against the oldest prediction
      if (result_valid && result_ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, got hit=%0b wb=%0b",
                   $time, result.hit, result.dirty_writeback);
          fail_count++;
        end else begin
          want = expected_lookups.pop_front();
          if (want.hit !== result.hit) begin
            $display("%0t: hit mismatch: expected %0b, got %0b",
                     $time, want.hit, result.hit);
            fail_count++;
          end
          if (want.dirty_writeback !== result.dirty_writeback) begin
            $display("%0t: dirty_writeback mismatch: expected %0b, got %0b",
                     $time, want.dirty_writeback, result.dirty_writeback);
            fail_count++;
          end
        end
      end
      // predict the result of an access transfer
      if (access_valid && access_ready) begin
        expected_lookups.push_back(predict_lookup(access));
      end
      outstanding = expected_lookups.size();
    end
  end

endmodule

// ----- sim/tb_lru_writeback_cache_set.sv -----
// ----------------------------------------------------------------------------
// tb_lru_writeback_cache_set
// Drives accesses into one cache set and takes its results under several
// patterns of sender gaps and receiver stalls. A directed run covers fills,
// hits, dirty and clean evictions and extreme tags; random accesses then
// draw mostly from a small working set of tags so that hits, LRU victims and
// write-backs all occur. The scoreboard beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_lru_writeback_cache_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned POOL_DEPTH   = 16;

  typedef logic [lwcs_pkg::LINE_TAG_W-1:0] tag_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              access_valid = 1'b0;
  logic              access_ready;
  lwcs_pkg::access_t access       = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  lwcs_pkg::result_t result;

  int          fail_count;
  int          outstanding;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  tag_t        tag_pool [POOL_DEPTH];
  int unsigned pool_used      = 8;

  lru_writeback_cache_set uut (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  lwcs_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic tag_t random_line_tag();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[lwcs_pkg::LINE_TAG_W-1:0];
  endfunction

  // Offer one access and hold it until the transfer; enter and leave on a
  // falling edge
  task automatic send_access(input tag_t tag, input logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      access_valid <= 1'b0;
      @(negedge clk);
    end
    access_valid    <= 1'b1;
    access.line_tag <= tag;
    access.is_write <= wr;
    do @(posedge clk); while (!access_ready);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been taken
  task automatic wait_for_results();
    access_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Mostly the working set, some fresh tags, a few edge patterns
  task automatic send_random_access();
    tag_t        tag;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      tag = tag_pool[$urandom_range(pool_used - 1)];
    end else if (pick < 95) begin
      tag = random_line_tag();
    end else begin
      case ($urandom_range(3))
        0:       tag = '0;
        1:       tag = '1;
        2:       tag = tag_t'(1) << $urandom_range(lwcs_pkg::LINE_TAG_W - 1);
        default: tag = ~(tag_t'(1) << $urandom_range(lwcs_pkg::LINE_TAG_W - 1));
      endcase
    end
    send_access(tag, 1'(($urandom_range(1))));
  endtask

  // Stop a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL lru_writeback_cache_set");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int unsigned phase;
    int unsigned k;
    int unsigned w;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty set: zero tag misses, all-ones write fills dirty
    send_access('0, 1'b0);
    send_access('1, 1'b1);
    // hit on a dirty line by a read keeps it dirty; write hit dirties a clean line
    send_access('1, 1'b0);
    send_access('0, 1'b1);
    send_access('0, 1'b0);
    // fill the remaining ways with alternating and single-bit patterns
    send_access({(lwcs_pkg::LINE_TAG_W/2){2'b01}}, 1'b0);
    send_access({(lwcs_pkg::LINE_TAG_W/2){2'b10}}, 1'b1);
    send_access(tag_t'(1), 1'b0);
    send_access(tag_t'(1) << (lwcs_pkg::LINE_TAG_W - 1), 1'b1);
    send_access(48'h0000_ffff_0000, 1'b0);
    send_access(48'hffff_0000_ffff, 1'b0);
    // full set: a hit, then misses that walk the LRU order
    send_access({(lwcs_pkg::LINE_TAG_W/2){2'b01}}, 1'b0);
    for (w = 0; w < 9; w++) begin
      send_access(48'h1234_0000_0000 + w, w[0]);
    end
    // bring back evicted extremes
    send_access('1, 1'b0);
    send_access('0, 1'b0);

    // random phases: none, sender gaps, receiver stalls, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      for (w = 0; w < POOL_DEPTH; w++) tag_pool[w] = random_line_tag();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // vary the working set: small sets mostly hit, large ones thrash
        if (k % 50 == 0) pool_used = $urandom_range(POOL_DEPTH, 3);
        if ($urandom_range(99) == 0) begin
          tag_pool[$urandom_range(POOL_DEPTH - 1)] = random_line_tag();
        end
        send_random_access();
      end
      wait_for_results();
    end

    // let any stray result show up
    recv_stall_pct = 0;
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS lru_writeback_cache_set");
    end else begin
      $display("FAIL lru_writeback_cache_set");
    end
    $finish;
  end

endmodule
